// ===== rtl/temp_humidity_compensation_assert.svh =====
// ----------------------------------------------------------------------------
// Temperature / humidity compensation assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TEMP_HUMIDITY_COMPENSATION_ASSERT_SVH
`define TEMP_HUMIDITY_COMPENSATION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define THC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("thc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define THC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("thc assertion failed");

`endif

// ===== rtl/thc_pkg.sv =====
// ----------------------------------------------------------------------------
// Temperature / humidity compensation package
// Request and result types, register indexes and compensation constants.
// ----------------------------------------------------------------------------
`default_nettype none

package thc_pkg;

    // Number of register stages from request to result.
    localparam int unsigned NUM_STAGES = 12;

    // Compensation constants.
    localparam logic [31:0] FINE_OFFSET = 32'd76800;
    localparam logic [31:0] HUM_ROUND   = 32'd16384;
    localparam logic [31:0] H3_BIAS     = 32'd32768;
    localparam logic [31:0] H_GAIN_BIAS = 32'd2097152;
    localparam logic [31:0] H2_ROUND    = 32'd8192;
    localparam logic [31:0] HUM_MAX     = 32'd419430400;
    localparam logic [31:0] TEMP_ROUND  = 32'd128;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_TEMP_COEF_ONE   = 3'd0,
        REG_TEMP_COEF_TWO   = 3'd1,
        REG_TEMP_COEF_THREE = 3'd2,
        REG_HUM_COEF_TWO    = 3'd3,
        REG_HUM_COEF_FOUR   = 3'd4,
        REG_HUM_COEF_FIVE   = 3'd5,
        REG_HUM_BYTE_COEFS  = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [19:0] raw_temp;
        logic [15:0] raw_humidity;
    } thc_sample_t;

    typedef struct packed {
        logic signed [31:0] fine_temp;
        logic signed [31:0] temp_centideg;
        logic [16:0]        humidity_q10;
    } thc_result_t;

    // Arithmetic right shift of a 32-bit two's complement word.
    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
        return 32'($signed(x) >>> n);
    endfunction

    // Low 32 bits of a 32 by 32 product; identical for signed and unsigned.
    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        return p[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/temp_humidity_compensation.sv =====
// ----------------------------------------------------------------------------
// Temperature / humidity compensation
// Applies the sensor's 32-bit integer compensation to raw temperature and
// humidity readings, one request per cycle, through a 12-stage pipeline.
// ----------------------------------------------------------------------------
//  Channel   Signals                         Direction  Transfer
//  request   start, busy, sample             in         start high, busy low
//  result    done, result                    out        done high, one cycle
//  config    wr_en, wr_index, wr_data        in         wr_en high
//
//  A request is taken every cycle; busy is always low.
//  The pipeline depth is set by the chain of dependent 32-bit
//  multiplications (eight multiply stages deep).
//  Reset clears the stage valid bits and the coefficient registers.
//  The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
`default_nettype none

module temp_humidity_compensation (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output      logic                  busy,
    input  wire thc_pkg::thc_sample_t  sample,
    output      logic                  done,
    output      thc_pkg::thc_result_t  result,
    input  wire logic                  wr_en,
    input  wire logic [2:0]            wr_index,
    input  wire logic [23:0]           wr_data
);

    // Coefficient registers.
    logic [15:0] t1_reg, t2_reg, t3_reg, h2_reg, h4_reg, h5_reg;
    logic [23:0] hb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
            h2_reg <= '0;
            h4_reg <= '0;
            h5_reg <= '0;
            hb_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                thc_pkg::REG_TEMP_COEF_ONE:   t1_reg <= wr_data[15:0];
                thc_pkg::REG_TEMP_COEF_TWO:   t2_reg <= wr_data[15:0];
                thc_pkg::REG_TEMP_COEF_THREE: t3_reg <= wr_data[15:0];
                thc_pkg::REG_HUM_COEF_TWO:    h2_reg <= wr_data[15:0];
                thc_pkg::REG_HUM_COEF_FOUR:   h4_reg <= wr_data[15:0];
                thc_pkg::REG_HUM_COEF_FIVE:   h5_reg <= wr_data[15:0];
                thc_pkg::REG_HUM_BYTE_COEFS:  hb_reg <= wr_data;
                default:                      ;
            endcase
        end
    end

    // Coefficients widened to 32 bits.
    logic [31:0] t1_w, t2_w, t3_w, h1_w, h2_w, h3_w, h4_w, h5_w, h6_w;

    assign t1_w = {16'b0, t1_reg};
    assign t2_w = {{16{t2_reg[15]}}, t2_reg};
    assign t3_w = {{16{t3_reg[15]}}, t3_reg};
    assign h1_w = {24'b0, hb_reg[7:0]};
    assign h2_w = {{16{h2_reg[15]}}, h2_reg};
    assign h3_w = {24'b0, hb_reg[15:8]};
    assign h4_w = {{16{h4_reg[15]}}, h4_reg};
    assign h5_w = {{16{h5_reg[15]}}, h5_reg};
    assign h6_w = {{24{hb_reg[23]}}, hb_reg[23:16]};

    // Stage valid bits; every stage advances each cycle.
    logic [thc_pkg::NUM_STAGES-1:0] vld_reg, vld_next;

    assign vld_next = {vld_reg[thc_pkg::NUM_STAGES-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Pipeline payload registers and their next values.
    logic [31:0] s1_x1_reg, s1_d_reg;
    logic [15:0] s1_hum_reg, s2_hum_reg, s3_hum_reg, s4_hum_reg, s5_hum_reg;
    logic [31:0] s2_m1_reg, s2_dd_reg;
    logic [31:0] s3_var1_reg, s3_m2_reg;
    logic [31:0] s4_fine_reg;
    logic [31:0] s5_fine_reg, s5_cent_reg, s5_p1_reg, s5_p2_reg, s5_p3_reg;
    logic [31:0] s6_fine_reg, s6_cent_reg, s6_a_reg, s6_b_reg, s6_c_reg;
    logic [31:0] s7_fine_reg, s7_cent_reg, s7_a_reg, s7_bc_reg;
    logic [31:0] s8_fine_reg, s8_cent_reg, s8_a_reg, s8_eh_reg;
    logic [31:0] s9_fine_reg, s9_cent_reg, s9_af_reg;
    logic [31:0] s10_fine_reg, s10_cent_reg, s10_af_reg, s10_gg_reg;
    logic [31:0] s11_fine_reg, s11_cent_reg, s11_af_reg, s11_gh_reg;
    thc_pkg::thc_result_t s12_res_reg;

    logic [31:0] s1_x1_next, s1_d_next;
    logic [31:0] s2_m1_next, s2_dd_next;
    logic [31:0] s3_var1_next, s3_m2_next;
    logic [31:0] s4_fine_next;
    logic [31:0] s5_v, s5_cent_next, s5_p1_next, s5_p2_next, s5_p3_next;
    logic [31:0] s6_a_next, s6_b_next, s6_c_next;
    logic [31:0] s7_bc_next;
    logic [31:0] s8_e, s8_eh_next;
    logic [31:0] s9_f, s9_af_next;
    logic [31:0] s10_g, s10_gg_next;
    logic [31:0] s11_gh_next;
    logic [31:0] s12_h, s12_v;
    thc_pkg::thc_result_t s12_res_next;

    // Stage 1: temperature differences.
    assign s1_x1_next = {15'b0, sample.raw_temp[19:3]} - {15'b0, t1_reg, 1'b0};
    assign s1_d_next  = {16'b0, sample.raw_temp[19:4]} - t1_w;

    // Stage 2: linear term product and square of the difference.
    assign s2_m1_next = thc_pkg::mul32(s1_x1_reg, t2_w);
    assign s2_dd_next = thc_pkg::mul32(s1_d_reg, s1_d_reg);

    // Stage 3: scale both terms and form the quadratic product.
    assign s3_var1_next = thc_pkg::asr(s2_m1_reg, 11);
    assign s3_m2_next   = thc_pkg::mul32(thc_pkg::asr(s2_dd_reg, 12), t3_w);

    // Stage 4: fine temperature.
    assign s4_fine_next = s3_var1_reg + thc_pkg::asr(s3_m2_reg, 14);

    // Stage 5: centidegrees and the humidity products of the fine offset.
    assign s5_cent_next = thc_pkg::asr({s4_fine_reg[29:0], 2'b0} + s4_fine_reg
                                       + thc_pkg::TEMP_ROUND, 8);
    assign s5_v       = s4_fine_reg - thc_pkg::FINE_OFFSET;
    assign s5_p1_next = thc_pkg::mul32(h5_w, s5_v);
    assign s5_p2_next = thc_pkg::mul32(s5_v, h6_w);
    assign s5_p3_next = thc_pkg::mul32(s5_v, h3_w);

    // Stage 6: humidity offset term and the two gain factors.
    assign s6_a_next = thc_pkg::asr({2'b0, s5_hum_reg, 14'b0} - {h4_w[11:0], 20'b0}
                                    - s5_p1_reg + thc_pkg::HUM_ROUND, 15);
    assign s6_b_next = thc_pkg::asr(s5_p2_reg, 10);
    assign s6_c_next = thc_pkg::asr(s5_p3_reg, 11) + thc_pkg::H3_BIAS;

    // Stage 7: product of the gain factors.
    assign s7_bc_next = thc_pkg::mul32(s6_b_reg, s6_c_reg);

    // Stage 8: biased gain times the humidity gain coefficient.
    assign s8_e      = thc_pkg::asr(s7_bc_reg, 10) + thc_pkg::H_GAIN_BIAS;
    assign s8_eh_next = thc_pkg::mul32(s8_e, h2_w);

    // Stage 9: humidity accumulator before the quadratic correction.
    assign s9_f       = thc_pkg::asr(s8_eh_reg + thc_pkg::H2_ROUND, 14);
    assign s9_af_next = thc_pkg::mul32(s8_a_reg, s9_f);

    // Stage 10: square of the scaled accumulator.
    assign s10_g       = thc_pkg::asr(s9_af_reg, 15);
    assign s10_gg_next = thc_pkg::mul32(s10_g, s10_g);

    // Stage 11: quadratic correction times H1.
    assign s11_gh_next = thc_pkg::mul32(thc_pkg::asr(s10_gg_reg, 7), h1_w);

    // Stage 12: subtract the correction, clamp and scale.
    assign s12_h = thc_pkg::asr(s11_gh_reg, 4);
    assign s12_v = s11_af_reg - s12_h;

    always_comb
    begin
        logic [31:0] clamped;
        priority if (s12_v[31])
        begin
            clamped = '0;
        end
        else if (s12_v > thc_pkg::HUM_MAX)
        begin
            clamped = thc_pkg::HUM_MAX;
        end
        else
        begin
            clamped = s12_v;
        end
        s12_res_next.fine_temp     = $signed(s11_fine_reg);
        s12_res_next.temp_centideg = $signed(s11_cent_reg);
        s12_res_next.humidity_q10  = clamped[28:12];
    end

    // Payload pipeline; data registers need no reset.
    always_ff @(posedge clk)
    begin
        s1_x1_reg    <= s1_x1_next;
        s1_d_reg     <= s1_d_next;
        s1_hum_reg   <= sample.raw_humidity;
        s2_m1_reg    <= s2_m1_next;
        s2_dd_reg    <= s2_dd_next;
        s2_hum_reg   <= s1_hum_reg;
        s3_var1_reg  <= s3_var1_next;
        s3_m2_reg    <= s3_m2_next;
        s3_hum_reg   <= s2_hum_reg;
        s4_fine_reg  <= s4_fine_next;
        s4_hum_reg   <= s3_hum_reg;
        s5_fine_reg  <= s4_fine_reg;
        s5_cent_reg  <= s5_cent_next;
        s5_p1_reg    <= s5_p1_next;
        s5_p2_reg    <= s5_p2_next;
        s5_p3_reg    <= s5_p3_next;
        s5_hum_reg   <= s4_hum_reg;
        s6_fine_reg  <= s5_fine_reg;
        s6_cent_reg  <= s5_cent_reg;
        s6_a_reg     <= s6_a_next;
        s6_b_reg     <= s6_b_next;
        s6_c_reg     <= s6_c_next;
        s7_fine_reg  <= s6_fine_reg;
        s7_cent_reg  <= s6_cent_reg;
        s7_a_reg     <= s6_a_reg;
        s7_bc_reg    <= s7_bc_next;
        s8_fine_reg  <= s7_fine_reg;
        s8_cent_reg  <= s7_cent_reg;
        s8_a_reg     <= s7_a_reg;
        s8_eh_reg    <= s8_eh_next;
        s9_fine_reg  <= s8_fine_reg;
        s9_cent_reg  <= s8_cent_reg;
        s9_af_reg    <= s9_af_next;
        s10_fine_reg <= s9_fine_reg;
        s10_cent_reg <= s9_cent_reg;
        s10_af_reg   <= s9_af_reg;
        s10_gg_reg   <= s10_gg_next;
        s11_fine_reg <= s10_fine_reg;
        s11_cent_reg <= s10_cent_reg;
        s11_af_reg   <= s10_af_reg;
        s11_gh_reg   <= s11_gh_next;
        s12_res_reg  <= s12_res_next;
    end

    // Outputs.
    assign busy   = 1'b0;
    assign done   = vld_reg[thc_pkg::NUM_STAGES-1];
    assign result = s12_res_reg;

    // Checks.
    `include "temp_humidity_compensation_assert.svh"

    `THC_ASSERT_NEXT(a_enter, start, vld_reg[0])
    `THC_ASSERT_NEXT(a_no_phantom, !start, !vld_reg[0])
    `THC_ASSERT_SAME(a_hum_range, done, result.humidity_q10 <= 17'd102400)

endmodule

`default_nettype wire

// ===== tb/sv/temp_humidity_compensation_tb.sv =====
// ----------------------------------------------------------------------------
// Temperature / humidity compensation testbench
// Sends raw temperature and humidity readings through the block under several
// calibration settings. An in-bench predictor computes the 32-bit integer
// compensation, and every result is checked field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module temp_humidity_compensation_tb;

    // Index with no register behind it; writes to it must be dropped.
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // Cycles with no request, result or write before the run is abandoned.
    localparam int unsigned STALL_LIMIT = 2000;

    // Random stream shape.
    localparam int unsigned STREAM_PHASES   = 8;
    localparam int unsigned PHASE_REQUESTS  = 150;
    localparam int unsigned IDLE_PERCENT    = 13;
    localparam int unsigned REPORT_LIMIT    = 10;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    thc_pkg::thc_sample_t  sample;
    logic                  done;
    thc_pkg::thc_result_t  result;
    logic                  wr_en;
    logic [2:0]            wr_index;
    logic [23:0]           wr_data;

    // Calibration copy kept by the bench.
    logic [15:0]  cal_t1;
    logic [15:0]  cal_t2;
    logic [15:0]  cal_t3;
    logic [15:0]  cal_h2;
    logic [15:0]  cal_h4;
    logic [15:0]  cal_h5;
    logic [23:0]  cal_hbytes;

    thc_pkg::thc_result_t  pending_readings[$];
    int unsigned  error_count;
    int unsigned  stall_cycles;
    bit           idle_enabled;

    temp_humidity_compensation DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .sample   (sample),
        .done     (done),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Arithmetic right shift done through a sign-filled 64-bit word.
    function automatic logic [31:0] shift_down(input logic [31:0] x, input int unsigned n);
        logic [63:0] wide;
        wide = {{32{x[31]}}, x};
        wide = wide >> n;
        return wide[31:0];
    endfunction

    // Compensated reading for one request under the current calibration.
    function automatic thc_pkg::thc_result_t compensate_reading(
        input thc_pkg::thc_sample_t s);
        logic [31:0] adc_t, adc_h;
        logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
        logic [31:0] lin_term, delta, quad_term, fine, cent;
        logic [31:0] offs, base_h, gain_b, gain_c, gain_e, gain_f, acc, sq, corr;
        thc_pkg::thc_result_t r;

        adc_t = {12'd0, s.raw_temp};
        adc_h = {16'd0, s.raw_humidity};
        t1 = {16'd0, cal_t1};
        t2 = {{16{cal_t2[15]}}, cal_t2};
        t3 = {{16{cal_t3[15]}}, cal_t3};
        h1 = {24'd0, cal_hbytes[7:0]};
        h2 = {{16{cal_h2[15]}}, cal_h2};
        h3 = {24'd0, cal_hbytes[15:8]};
        h4 = {{16{cal_h4[15]}}, cal_h4};
        h5 = {{16{cal_h5[15]}}, cal_h5};
        h6 = {{24{cal_hbytes[23]}}, cal_hbytes[23:16]};

        // Temperature: linear and quadratic terms, all 32-bit wrapping.
        lin_term = ((adc_t >> 3) - (t1 << 1)) * t2;
        lin_term = shift_down(lin_term, 11);
        delta = (adc_t >> 4) - t1;
        quad_term = shift_down(delta * delta, 12) * t3;
        quad_term = shift_down(quad_term, 14);
        fine = lin_term + quad_term;
        cent = shift_down(fine * 32'd5 + thc_pkg::TEMP_ROUND, 8);

        // Humidity: offset term times temperature-dependent gain.
        offs = fine - thc_pkg::FINE_OFFSET;
        base_h = (adc_h << 14) - (h4 << 20) - h5 * offs;
        base_h = shift_down(base_h + thc_pkg::HUM_ROUND, 15);
        gain_b = shift_down(offs * h6, 10);
        gain_c = shift_down(offs * h3, 11) + thc_pkg::H3_BIAS;
        gain_e = shift_down(gain_b * gain_c, 10) + thc_pkg::H_GAIN_BIAS;
        gain_f = shift_down(gain_e * h2 + thc_pkg::H2_ROUND, 14);
        acc = base_h * gain_f;
        sq = shift_down(acc, 15);
        corr = shift_down(shift_down(sq * sq, 7) * h1, 4);
        acc = acc - corr;

        // Clamp the signed accumulator to the legal humidity range.
        if (acc[31])
            acc = 32'd0;
        else if (acc > thc_pkg::HUM_MAX)
            acc = thc_pkg::HUM_MAX;

        r.fine_temp     = fine;
        r.temp_centideg = cent;
        r.humidity_q10  = acc[28:12];
        return r;
    endfunction

    // Record a failure; only the first few are printed.
    task automatic report_error(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("ERROR %s: expected %h, got %h", what, want, got);
    endtask

    // Each accepted request adds its predicted result.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            pending_readings.push_back(compensate_reading(sample));
    end

    // Each result is compared against the oldest prediction.
    always @(posedge clk)
    begin
        thc_pkg::thc_result_t want;
        if (rst_n && done)
        begin
            if (pending_readings.size() == 0)
            begin
                report_error("result with no request", 32'd0, result.fine_temp);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (result.fine_temp !== want.fine_temp)
                    report_error("fine_temp", want.fine_temp, result.fine_temp);
                if (result.temp_centideg !== want.temp_centideg)
                    report_error("temp_centideg", want.temp_centideg, result.temp_centideg);
                if (result.humidity_q10 !== want.humidity_q10)
                    report_error("humidity_q10", {15'd0, want.humidity_q10},
                                 {15'd0, result.humidity_q10});
            end
        end
    end

    // Watchdog on cycles where nothing moves.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || wr_en)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Write one register and mirror it in the bench copy.
    task automatic write_register(input logic [2:0] idx, input logic [23:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        case (idx)
            thc_pkg::REG_TEMP_COEF_ONE:   cal_t1     = data[15:0];
            thc_pkg::REG_TEMP_COEF_TWO:   cal_t2     = data[15:0];
            thc_pkg::REG_TEMP_COEF_THREE: cal_t3     = data[15:0];
            thc_pkg::REG_HUM_COEF_TWO:    cal_h2     = data[15:0];
            thc_pkg::REG_HUM_COEF_FOUR:   cal_h4     = data[15:0];
            thc_pkg::REG_HUM_COEF_FIVE:   cal_h5     = data[15:0];
            thc_pkg::REG_HUM_BYTE_COEFS:  cal_hbytes = data;
            default: ;
        endcase
    endtask

    // Load the full calibration set, then drop the write enable.
    task automatic load_calibration(input logic [23:0] t1, input logic [23:0] t2,
                                    input logic [23:0] t3, input logic [23:0] h2,
                                    input logic [23:0] h4, input logic [23:0] h5,
                                    input logic [23:0] hbytes);
        write_register(thc_pkg::REG_TEMP_COEF_ONE, t1);
        write_register(thc_pkg::REG_TEMP_COEF_TWO, t2);
        write_register(thc_pkg::REG_TEMP_COEF_THREE, t3);
        write_register(thc_pkg::REG_HUM_COEF_TWO, h2);
        write_register(thc_pkg::REG_HUM_COEF_FOUR, h4);
        write_register(thc_pkg::REG_HUM_COEF_FIVE, h5);
        write_register(thc_pkg::REG_HUM_BYTE_COEFS, hbytes);
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    // Typical factory calibration, optionally nudged by a random amount.
    task automatic load_typical(input bit nudge);
        int d1, d2, d3;
        d1 = nudge ? int'($urandom_range(0, 4000)) - 2000 : 0;
        d2 = nudge ? int'($urandom_range(0, 4000)) - 2000 : 0;
        d3 = nudge ? int'($urandom_range(0, 400)) - 200 : 0;
        load_calibration(24'(27504 + d1), 24'(26435 + d2), 24'(-1000 + d3),
                         24'd362, 24'd313, 24'd50,
                         {8'd30, nudge ? 8'($urandom_range(0, 255)) : 8'd0, 8'd75});
    endtask

    // Send one request, with an occasional idle gap in front of it.
    task automatic send_reading(input logic [19:0] raw_t, input logic [15:0] raw_h);
        @(negedge clk);
        if (idle_enabled)
        begin
            while ($urandom_range(0, 99) < IDLE_PERCENT)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
        start  <= 1'b1;
        sample <= '{raw_temp: raw_t, raw_humidity: raw_h};
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stop requesting and wait for every predicted result to arrive.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
    endtask

    // All coefficients are zero out of reset.
    task automatic test_reset_calibration();
        send_reading(20'd0, 16'd0);
        send_reading(20'hFFFFF, 16'hFFFF);
        drain_results();
    endtask

    // Extremes of both raw fields under a typical calibration.
    task automatic test_field_extremes();
        load_typical(1'b0);
        send_reading(20'd0, 16'd0);
        send_reading(20'd0, 16'hFFFF);
        send_reading(20'hFFFFF, 16'd0);
        send_reading(20'hFFFFF, 16'hFFFF);
        send_reading(20'd519888, 16'd30000);
        drain_results();
    endtask

    // Largest and most negative coefficients force wraparound everywhere.
    task automatic test_coefficient_extremes();
        load_calibration(24'h00FFFF, 24'h007FFF, 24'h007FFF, 24'h007FFF,
                         24'h007FFF, 24'h007FFF, 24'h7FFFFF);
        send_reading(20'd0, 16'd0);
        send_reading(20'hFFFFF, 16'hFFFF);
        send_reading(20'h80000, 16'h8000);
        drain_results();
        load_calibration(24'h000000, 24'h008000, 24'h008000, 24'h008000,
                         24'h008000, 24'h008000, 24'h80FF00);
        send_reading(20'd0, 16'hFFFF);
        send_reading(20'hFFFFF, 16'd0);
        send_reading(20'h7FFFF, 16'h7FFF);
        drain_results();
    endtask

    // Humidity saturates low on a dry reading and high on a wet one.
    task automatic test_humidity_clamp();
        load_typical(1'b0);
        send_reading(20'd519888, 16'd0);
        send_reading(20'd519888, 16'hFFFF);
        drain_results();
    endtask

    // Writes to the unused index are dropped; wide data is truncated.
    task automatic test_register_write_masking();
        write_register(REG_UNUSED, 24'hA5A5A5);
        write_register(thc_pkg::REG_TEMP_COEF_TWO, 24'hFF6744);
        @(negedge clk);
        wr_en <= 1'b0;
        send_reading(20'd519888, 16'd30000);
        send_reading(20'd300000, 16'd50000);
        drain_results();
    endtask

    // Random readings under a fresh calibration in each phase.
    task automatic test_random_stream();
        int unsigned mode;
        int          centre;
        logic [19:0] raw_t;
        logic [15:0] extremes[4];
        extremes = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
        for (int unsigned p = 0; p < STREAM_PHASES; p++)
        begin
            // The first phase runs back to back with no gaps.
            idle_enabled = (p != 0);
            mode = $urandom_range(0, 3);
            if (mode <= 1)
                load_typical(1'b1);
            else if (mode == 2)
                load_calibration(24'($urandom), 24'($urandom), 24'($urandom),
                                 24'($urandom), 24'($urandom), 24'($urandom),
                                 24'($urandom));
            else
                load_calibration({8'($urandom), extremes[2'($urandom_range(0, 3))]},
                                 {8'($urandom), extremes[2'($urandom_range(0, 3))]},
                                 {8'($urandom), extremes[2'($urandom_range(0, 3))]},
                                 {8'($urandom), extremes[2'($urandom_range(0, 3))]},
                                 {8'($urandom), extremes[2'($urandom_range(0, 3))]},
                                 {8'($urandom), extremes[2'($urandom_range(0, 3))]},
                                 {extremes[2'($urandom_range(0, 3))][15:8],
                                  extremes[2'($urandom_range(0, 3))]});
            for (int unsigned i = 0; i < PHASE_REQUESTS; i++)
            begin
                // Most temperatures sit near the calibrated operating point.
                if ($urandom_range(0, 9) < 7)
                begin
                    centre = int'(cal_t1) * 16 + int'($urandom_range(0, 65535)) - 32768;
                    if (centre < 0)
                        centre = 0;
                    else if (centre > 20'hFFFFF)
                        centre = 20'hFFFFF;
                    raw_t = 20'(centre);
                end
                else
                begin
                    raw_t = 20'($urandom);
                end
                send_reading(raw_t, 16'($urandom));
            end
            drain_results();
        end
    endtask

    // Main sequence.
    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        sample       = '0;
        wr_en        = 1'b0;
        wr_index     = '0;
        wr_data      = '0;
        cal_t1       = '0;
        cal_t2       = '0;
        cal_t3       = '0;
        cal_h2       = '0;
        cal_h4       = '0;
        cal_h5       = '0;
        cal_hbytes   = '0;
        error_count  = 0;
        idle_enabled = 1'b1;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_calibration();
        test_field_extremes();
        test_coefficient_extremes();
        test_humidity_clamp();
        test_register_write_masking();
        test_random_stream();

        // Let any stray result show up before the verdict.
        repeat (thc_pkg::NUM_STAGES + 8) @(posedge clk);
        if (pending_readings.size() != 0)
            report_error("results never arrived", 32'(pending_readings.size()), 32'd0);

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
